// File: design/asg_pkg.sv
// ----------------------------------------------------------------------------
// asg_pkg
// Shared constants and types of the adaptive sample gate.
// ----------------------------------------------------------------------------
package asg_pkg;

   localparam int STEP_W     = 32;   // stored step, Q16
   localparam int VAL_W      = 48;   // result value, Q31.16
   localparam int FRAC_BITS  = 16;
   localparam int WS_W       = 8;
   localparam int THR_W      = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int PORT_W     = 2;
   localparam int PASS_CNT_W = 7;
   localparam int TREND_LIMIT = 3;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_BITS   = 8;    // quotient bits per divider cycle

   localparam logic [PASS_CNT_W-1:0] PASS_ITEMS = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEVIATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_JUMP    = 2'd2;

   localparam logic [WS_W-1:0]  WS_RESET     = 8'd10;
   localparam logic [THR_W-1:0] MINDEV_RESET = 12'd0;
   localparam logic [THR_W-1:0] FJUMP_RESET  = 12'd50;

   localparam logic [PORT_W-1:0] PORT_GATE = 2'd0;
   localparam logic [PORT_W-1:0] PORT_DEV  = 2'd1;
   localparam logic [PORT_W-1:0] PORT_MSQ  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: design/adaptive_sample_gate.sv
// ----------------------------------------------------------------------------
// adaptive_sample_gate
// Gate for converter samples driven by window statistics of the steps.
// ----------------------------------------------------------------------------
// One sample enters per item on req_ (valid/ready). Each item gives two to
// five results on rsp_: the previous mean-square step (port 2), the
// age-weighted deviation (port 1), then up to three gated values on port 0.
// rsp_last marks the final result of an item. Values are Q31.16.
// Settings are to be written on csr_ only while the block is idle; the block
// itself does not enforce this. Both windows live in one RAM of MAX_WINDOW
// words (sample and step). An item runs a plain pass over the window, then
// a weighted pass (read, multiply, divide, accumulate for each entry); four
// more divides and a square root make up the rest. A jump then refills the
// window, and results go out at one result per cycle while rsp_ready stays
// high. The shared divider and the one RAM read port mean that items are
// taken one at a time. After reset every RAM word is swept to zero;
// req_ready stays low meanwhile. The last result waits in the output
// register while the next item is accepted; other results wait for
// rsp_ready.
// ----------------------------------------------------------------------------
module adaptive_sample_gate #(
   parameter int MAX_WINDOW  = 128,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [asg_pkg::PORT_W-1:0]       rsp_port,
   output logic [asg_pkg::VAL_W-1:0]        rsp_value,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [asg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [asg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import asg_pkg::*;

   localparam int AW     = $clog2(MAX_WINDOW);
   localparam int NW     = $clog2(MAX_WINDOW + 1);
   localparam int DEN_W  = NW + 1;
   localparam int SUM_W  = STEP_W + NW;
   localparam int SSUM_W = SAMPLE_BITS + NW;
   localparam int RW     = SAMPLE_BITS + STEP_W;
   localparam int SB     = SAMPLE_BITS;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_STEPDIV = 4'd2;
   localparam logic [3:0] S_WRITE   = 4'd3;
   localparam logic [3:0] S_P1      = 4'd4;
   localparam logic [3:0] S_MEANDIV = 4'd5;
   localparam logic [3:0] S_WMDIV   = 4'd6;
   localparam logic [3:0] S_P2RD    = 4'd7;
   localparam logic [3:0] S_P2MUL   = 4'd8;
   localparam logic [3:0] S_P2DIV   = 4'd9;
   localparam logic [3:0] S_P2ACC   = 4'd10;
   localparam logic [3:0] S_DEVDIV  = 4'd11;
   localparam logic [3:0] S_SQRT    = 4'd12;
   localparam logic [3:0] S_DECIDE  = 4'd13;
   localparam logic [3:0] S_FLOOD   = 4'd14;
   localparam logic [3:0] S_EMIT    = 4'd15;

   localparam logic [2:0] EM_MSQ   = 3'd0;
   localparam logic [2:0] EM_DEV   = 3'd1;
   localparam logic [2:0] EM_PASS  = 3'd2;
   localparam logic [2:0] EM_TREND = 3'd3;
   localparam logic [2:0] EM_FINAL = 3'd4;

   // control and block state
   logic [3:0]            state_ff, state_in;
   logic [WS_W-1:0]       ws_ff, ws_in;
   logic [THR_W-1:0]      mindev_ff, mindev_in;
   logic [THR_W-1:0]      fjump_ff, fjump_in;
   logic [SB-1:0]         prev_ff, prev_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [SB-1:0]         wmean_ff, wmean_in;
   logic [VAL_W-1:0]      msq_ff, msq_in;
   logic                  pass_act_ff, pass_act_in;
   logic [PASS_CNT_W-1:0] pass_cnt_ff, pass_cnt_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [4:0]            emit_mask_ff, emit_mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  div_start_ff, div_start_in;

   // per-item working registers
   logic [SB-1:0]         smp_ff, smp_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [VAL_W-1:0]      msq_old_ff, msq_old_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic                  jneg_ff, jneg_in;
   logic [SB-1:0]         ajump_ff, ajump_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SSUM_W-1:0]     ssum_ff, ssum_in;
   logic [NW-1:0]         rise_ff, rise_in;
   logic [NW-1:0]         fall_ff, fall_in;
   logic [STEP_W-1:0]     mean_ff, mean_in;
   logic [STEP_W-1:0]     mean_mag_ff, mean_mag_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [NW-1:0]         c_ff, c_in;
   logic [63:0]           sqacc_ff, sqacc_in;
   logic [63:0]           sq_ff, sq_in;
   logic [63:0]           sv_ff, sv_in;
   logic [63:0]           sr_ff, sr_in;
   logic [63:0]           sbit_ff, sbit_in;
   logic [VAL_W-1:0]      dev_val_ff, dev_val_in;
   logic                  final_jump_ff, final_jump_in;
   logic [PORT_W-1:0]     rsp_port_ff, rsp_port_in;
   logic [VAL_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIV_NUM_W-1:0]  div_num_ff, div_num_in;
   logic [DEN_W-1:0]      div_den_ff, div_den_in;

   // RAM and divider hookup
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [RW-1:0]         ram_wdata, ram_rdata;
   logic [DIV_NUM_W-1:0]  div_quo;
   div_status_type        div_stat;

   // combinational helpers
   logic [NW-1:0]             n_eff;
   logic                      req_jneg;
   logic [SB-1:0]             req_ajump;
   logic [STEP_W-1:0]         rd_step;
   logic [SB-1:0]             rd_smp;
   logic                      p1_issue;
   logic [SUM_W-1:0]          sum_mag;
   logic [STEP_W-1:0]         q32;
   logic [63:0]               msq_prod;
   logic [STEP_W:0]           p2_d, p2_dneg;
   logic [STEP_W-1:0]         p2_dmag;
   logic [DEN_W-1:0]          p2_w;
   logic [STEP_W+DEN_W-1:0]   p2_prod;
   logic [63:0]               sq_prod;
   logic [64:0]               acc_sum;
   logic [63:0]               sqrt_t;
   logic [STEP_W-1:0]         dev_mag;
   logic                      jump_hit, dev_hit, pass_hit, trend_hit;
   logic [2:0]                em_sel;
   logic [4:0]                em_rest;
   logic [VAL_W-1:0]          raw_val, wm_val;
   logic                      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_port  = rsp_port_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   assign n_eff = (ws_ff == '0) ? NW'(1)
                : (32'(ws_ff) > MAX_WINDOW) ? NW'(MAX_WINDOW) : NW'(ws_ff);

   assign req_jneg  = (req_sample < prev_ff);
   assign req_ajump = req_jneg ? (prev_ff - req_sample) : (req_sample - prev_ff);

   assign rd_step  = ram_rdata[STEP_W-1:0];
   assign rd_smp   = ram_rdata[RW-1:STEP_W];
   assign p1_issue = (cnt_ff < n_ff);
   assign sum_mag  = sum_ff[SUM_W-1] ? (-sum_ff) : sum_ff;
   assign q32      = div_quo[STEP_W-1:0];
   assign msq_prod = mean_mag_ff * mean_mag_ff;

   assign p2_d    = {rd_step[STEP_W-1], rd_step} - {mean_ff[STEP_W-1], mean_ff};
   assign p2_dneg = -p2_d;
   assign p2_dmag = p2_d[STEP_W] ? p2_dneg[STEP_W-1:0] : p2_d[STEP_W-1:0];
   // age weight 2n - c
   assign p2_w    = {n_ff, 1'b0} - DEN_W'(c_ff);
   assign p2_prod = p2_dmag * p2_w;
   assign sq_prod = q32 * q32;
   assign acc_sum = {1'b0, sqacc_ff} + {1'b0, sq_ff};
   assign sqrt_t  = sr_ff + sbit_ff;

   assign dev_mag   = sr_ff[STEP_W-1:0];
   assign jump_hit  = (32'(ajump_ff) > 32'(fjump_ff));
   assign dev_hit   = (dev_mag >= 32'({mindev_ff, {FRAC_BITS{1'b0}}}));
   assign pass_hit  = pass_act_ff && (pass_cnt_ff < PASS_ITEMS);
   assign trend_hit = ({1'b0, rise_ff} > ({1'b0, fall_ff} + (NW+1)'(TREND_LIMIT)))
                   || ({1'b0, fall_ff} > ({1'b0, rise_ff} + (NW+1)'(TREND_LIMIT)));

   assign raw_val  = VAL_W'({smp_ff, {FRAC_BITS{1'b0}}});
   assign wm_val   = VAL_W'({wmean_ff, {FRAC_BITS{1'b0}}});
   assign out_free = !rsp_valid_ff || rsp_ready;

   // lowest pending result goes next
   always_comb begin : emit_pick
      logic found;
      found  = 1'b0;
      em_sel = EM_MSQ;
      for (int k = 0; k < 5; k++) begin
         if (!found && emit_mask_ff[k]) begin
            em_sel = 3'(k);
            found  = 1'b1;
         end
      end
      em_rest = emit_mask_ff & ~(5'b00001 << em_sel);
   end

   always_comb begin
      state_in      = state_ff;
      ws_in         = ws_ff;
      mindev_in     = mindev_ff;
      fjump_in      = fjump_ff;
      prev_in       = prev_ff;
      slot_in       = slot_ff;
      wmean_in      = wmean_ff;
      msq_in        = msq_ff;
      pass_act_in   = pass_act_ff;
      pass_cnt_in   = pass_cnt_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      emit_mask_in  = emit_mask_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      div_start_in  = 1'b0;
      smp_in        = smp_ff;
      n_in          = n_ff;
      msq_old_in    = msq_old_ff;
      cur_in        = cur_ff;
      jneg_in       = jneg_ff;
      ajump_in      = ajump_ff;
      step_in       = step_ff;
      sum_in        = sum_ff;
      ssum_in       = ssum_ff;
      rise_in       = rise_ff;
      fall_in       = fall_ff;
      mean_in       = mean_ff;
      mean_mag_in   = mean_mag_ff;
      idx_in        = idx_ff;
      c_in          = c_ff;
      sqacc_in      = sqacc_ff;
      sq_in         = sq_ff;
      sv_in         = sv_ff;
      sr_in         = sr_ff;
      sbit_in       = sbit_ff;
      dev_val_in    = dev_val_ff;
      final_jump_in = final_jump_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff[AW-1:0];
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff[AW-1:0];

      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_SIZE:   ws_in     = csr_wdata[WS_W-1:0];
            CSR_MIN_DEVIATION: mindev_in = csr_wdata[THR_W-1:0];
            CSR_FORCE_JUMP:    fjump_in  = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(MAX_WINDOW - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               smp_in     = req_sample;
               n_in       = n_eff;
               msq_old_in = msq_ff;
               // a slot left over from a larger window restarts at 0
               cur_in     = (NW'(slot_ff) >= n_eff) ? '0 : slot_ff;
               jneg_in    = req_jneg;
               ajump_in   = req_ajump;
               div_start_in = 1'b1;
               div_num_in   = DIV_NUM_W'({req_ajump, {FRAC_BITS{1'b0}}});
               div_den_in   = DEN_W'(n_eff);
               state_in     = S_STEPDIV;
            end
         end
         S_STEPDIV: begin
            if (div_stat.done) begin
               step_in  = jneg_ff ? (-q32) : q32;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            ram_wdata = {smp_ff, step_ff};
            cnt_in    = '0;
            sum_in    = '0;
            ssum_in   = '0;
            rise_in   = '0;
            fall_in   = '0;
            state_in  = S_P1;
         end
         S_P1: begin
            ram_re  = p1_issue;
            pend_in = p1_issue;
            if (p1_issue) begin
               cnt_in = cnt_ff + NW'(1);
            end
            if (pend_ff) begin
               sum_in  = sum_ff + {{NW{rd_step[STEP_W-1]}}, rd_step};
               ssum_in = ssum_ff + SSUM_W'(rd_smp);
               if (rd_step[STEP_W-1]) begin
                  fall_in = fall_ff + NW'(1);
               end else if (rd_step != '0) begin
                  rise_in = rise_ff + NW'(1);
               end
            end
            if (!p1_issue && !pend_ff) begin
               div_start_in = 1'b1;
               div_num_in   = DIV_NUM_W'(sum_mag);
               div_den_in   = DEN_W'(n_ff);
               state_in     = S_MEANDIV;
            end
         end
         S_MEANDIV: begin
            if (div_stat.done) begin
               mean_mag_in  = q32;
               mean_in      = sum_ff[SUM_W-1] ? (-q32) : q32;
               div_start_in = 1'b1;
               div_num_in   = DIV_NUM_W'(ssum_ff);
               div_den_in   = DEN_W'(n_ff);
               state_in     = S_WMDIV;
            end
         end
         S_WMDIV: begin
            if (div_stat.done) begin
               wmean_in = div_quo[SB-1:0];
               msq_in   = msq_prod[FRAC_BITS +: VAL_W];
               idx_in   = cur_ff;
               c_in     = '0;
               sqacc_in = '0;
               state_in = S_P2RD;
            end
         end
         S_P2RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff;
            state_in  = S_P2MUL;
         end
         S_P2MUL: begin
            div_start_in = 1'b1;
            div_num_in   = DIV_NUM_W'(p2_prod);
            div_den_in   = {n_ff, 1'b0};
            state_in     = S_P2DIV;
         end
         S_P2DIV: begin
            if (div_stat.done) begin
               sq_in    = sq_prod;
               state_in = S_P2ACC;
            end
         end
         S_P2ACC: begin
            sqacc_in = acc_sum[64] ? '1 : acc_sum[63:0];
            if (c_ff + NW'(1) == n_ff) begin
               div_start_in = 1'b1;
               div_num_in   = acc_sum[64] ? '1 : acc_sum[63:0];
               div_den_in   = DEN_W'(n_ff);
               state_in     = S_DEVDIV;
            end else begin
               c_in     = c_ff + NW'(1);
               idx_in   = (NW'(idx_ff) + NW'(1) >= n_ff) ? '0 : idx_ff + AW'(1);
               state_in = S_P2RD;
            end
         end
         S_DEVDIV: begin
            if (div_stat.done) begin
               sv_in    = div_quo;
               sr_in    = '0;
               sbit_in  = 64'h4000_0000_0000_0000;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sv_ff >= sqrt_t) begin
               sv_in = sv_ff - sqrt_t;
               sr_in = (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff == 64'd1) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            dev_val_in    = mean_ff[STEP_W-1] ? (-VAL_W'(dev_mag)) : VAL_W'(dev_mag);
            final_jump_in = jump_hit;
            emit_mask_in  = {jump_hit || dev_hit, trend_hit, pass_hit, 1'b1, 1'b1};
            if (jump_hit || dev_hit) begin
               pass_act_in = 1'b1;
               pass_cnt_in = '0;
            end else if (pass_hit) begin
               pass_cnt_in = pass_cnt_ff + PASS_CNT_W'(1);
            end else begin
               pass_act_in = 1'b0;
               pass_cnt_in = '0;
            end
            prev_in = smp_ff;
            slot_in = (NW'(cur_ff) + NW'(1) >= n_ff) ? '0 : cur_ff + AW'(1);
            cnt_in  = '0;
            state_in = jump_hit ? S_FLOOD : S_EMIT;
         end
         S_FLOOD: begin
            // a jump refills the whole window with the new sample, zero step
            ram_we    = 1'b1;
            ram_wdata = {smp_ff, {STEP_W{1'b0}}};
            cnt_in    = cnt_ff + NW'(1);
            if (cnt_ff + NW'(1) == n_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (em_rest == '0);
               emit_mask_in = em_rest;
               case (em_sel)
                  EM_MSQ: begin
                     rsp_port_in  = PORT_MSQ;
                     rsp_value_in = msq_old_ff;
                  end
                  EM_DEV: begin
                     rsp_port_in  = PORT_DEV;
                     rsp_value_in = dev_val_ff;
                  end
                  EM_PASS, EM_TREND: begin
                     rsp_port_in  = PORT_GATE;
                     rsp_value_in = raw_val;
                  end
                  EM_FINAL: begin
                     rsp_port_in  = PORT_GATE;
                     rsp_value_in = final_jump_ff ? raw_val : wm_val;
                  end
                  default: begin
                     rsp_port_in  = PORT_GATE;
                     rsp_value_in = raw_val;
                  end
               endcase
               if (em_rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ws_ff        <= WS_RESET;
         mindev_ff    <= MINDEV_RESET;
         fjump_ff     <= FJUMP_RESET;
         prev_ff      <= '0;
         slot_ff      <= '0;
         wmean_ff     <= '0;
         msq_ff       <= '0;
         pass_act_ff  <= 1'b0;
         pass_cnt_ff  <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         emit_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         mindev_ff    <= mindev_in;
         fjump_ff     <= fjump_in;
         prev_ff      <= prev_in;
         slot_ff      <= slot_in;
         wmean_ff     <= wmean_in;
         msq_ff       <= msq_in;
         pass_act_ff  <= pass_act_in;
         pass_cnt_ff  <= pass_cnt_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         emit_mask_ff <= emit_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= div_start_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff        <= smp_in;
      n_ff          <= n_in;
      msq_old_ff    <= msq_old_in;
      cur_ff        <= cur_in;
      jneg_ff       <= jneg_in;
      ajump_ff      <= ajump_in;
      step_ff       <= step_in;
      sum_ff        <= sum_in;
      ssum_ff       <= ssum_in;
      rise_ff       <= rise_in;
      fall_ff       <= fall_in;
      mean_ff       <= mean_in;
      mean_mag_ff   <= mean_mag_in;
      idx_ff        <= idx_in;
      c_ff          <= c_in;
      sqacc_ff      <= sqacc_in;
      sq_ff         <= sq_in;
      sv_ff         <= sv_in;
      sr_ff         <= sr_in;
      sbit_ff       <= sbit_in;
      dev_val_ff    <= dev_val_in;
      final_jump_ff <= final_jump_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
   end

   asg_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   asg_div #(
      .DEN_W (DEN_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_ff),
      .num    (div_num_ff),
      .den    (div_den_ff),
      .quo    (div_quo),
      .status (div_stat)
   );

   // no divide may still run once the block takes a new item
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_stat.busy)
      else $error("divider busy while idle");

   a_emit_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (emit_mask_ff != '0))
      else $error("emit state with nothing pending");

   a_p2_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P2RD) |-> ((NW'(idx_ff) < n_ff) && (c_ff < n_ff)))
      else $error("weighted pass out of window");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_STEPDIV || state_ff == S_MEANDIV ||
                         state_ff == S_WMDIV || state_ff == S_P2DIV ||
                         state_ff == S_DEVDIV))
      else $error("divide result with no consumer");

endmodule

// File: design/asg_ram.sv
// ----------------------------------------------------------------------------
// asg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/asg_div.sv
// ----------------------------------------------------------------------------
// asg_div
// Unsigned restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module asg_div #(
   parameter int DEN_W = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [asg_pkg::DIV_NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]               den,
   output logic [asg_pkg::DIV_NUM_W-1:0]  quo,
   output asg_pkg::div_status_type        status
);
   import asg_pkg::*;

   localparam int ITER  = DIV_NUM_W / DIV_BITS;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]       rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;

   always_comb begin : div_step
      logic [DEN_W:0]       r;
      logic [DIV_NUM_W-1:0] q;
      r       = rem_ff;
      q       = quo_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(ITER);
         quo_in = num;
         rem_in = '0;
         den_in = den;
      end else if (cnt_ff != '0) begin
         // numerator bits shift out the top, quotient bits shift in below
         for (int k = 0; k < DIV_BITS; k++) begin
            r = {r[DEN_W-1:0], q[DIV_NUM_W-1]};
            q = {q[DIV_NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den_ff}) begin
               r    = r - {1'b0, den_ff};
               q[0] = 1'b1;
            end
         end
         quo_in  = q;
         rem_in  = r;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo         = quo_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

// File: dv/adaptive_sample_gate_tb.sv
// ----------------------------------------------------------------------------
// adaptive_sample_gate_tb
// Self-checking bench for the adaptive sample gate. Samples are driven on the
// req_ channel. A behavioral predictor keeps its own windows and statistics
// and queues the results each sample should give. Every rsp_ item is checked
// against that queue. The run steps through several register settings and
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module adaptive_sample_gate_tb;
   import asg_pkg::*;

   localparam int WIN_MAX = 128;
   localparam int SETTLE  = 2500;   // cycles; covers one item at the largest window

   typedef struct {
      logic [PORT_W-1:0] port;
      logic [VAL_W-1:0]  value;
      logic              last;
   } result_type;

   typedef struct {
      logic [11:0] sample;
      logic        typed;
      int          n_res;
      longint      last_val;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [11:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PORT_W-1:0] rsp_port;
   logic [VAL_W-1:0] rsp_value;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   adaptive_sample_gate i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_sample,
      .rsp_valid, .rsp_ready, .rsp_port, .rsp_value, .rsp_last,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  ws_reg = WS_RESET;
   logic [11:0] mindev_reg = MINDEV_RESET;
   logic [11:0] fjump_reg = FJUMP_RESET;
   logic [11:0] smp_win [WIN_MAX];
   longint      step_win [WIN_MAX];
   logic [11:0] prev_smp;
   int          wr_slot;
   longint      win_mean;
   longint      msq_step;
   logic        pass_on;
   int          pass_cnt;

   result_type gated_q[$];
   int      n_pushed = 0;
   int      errors = 0;
   int      snd_idle_pct = 0;
   int      rcv_stall_pct = 0;
   int      hold_cycles = 0;

   task automatic report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic void push_result(logic [PORT_W-1:0] p, longint v);
      result_type r;
      r.port = p;
      r.value = v[VAL_W-1:0];
      r.last = 1'b0;
      gated_q.push_back(r);
      n_pushed++;
   endfunction

   function automatic void predict_sample(logic [11:0] s);
      longint n, jump, sum, mean, dev, d, e, raw;
      longint unsigned acc, sq;
      int rise, fall, dir, idx;
      n = (ws_reg == 0) ? 1 : (ws_reg > WIN_MAX) ? WIN_MAX : ws_reg;
      jump = longint'(s) - longint'(prev_smp);
      raw = longint'(s) * 65536;
      if (wr_slot >= n) wr_slot = 0;
      step_win[wr_slot] = (jump * 65536) / n;
      smp_win[wr_slot] = s;
      push_result(PORT_MSQ, msq_step);

      sum = 0; acc = 0; rise = 0; fall = 0;
      for (int i = 0; i < n; i++) begin
         if (step_win[i] > 0) rise++;
         else if (step_win[i] < 0) fall++;
         sum += step_win[i];
         acc += smp_win[i];
      end
      mean = sum / n;
      msq_step = (mean * mean) >>> 16;
      dir = rise - fall;
      win_mean = acc / n;

      // age-weighted spread, starting at the slot just written (newest entry)
      acc = 0;
      idx = wr_slot;
      for (int c = 0; c < n; c++) begin
         d = step_win[idx] - mean;
         e = (d * (2 * n - c)) / (2 * n);
         sq = e * e;
         acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
         idx = (idx + 1 >= n) ? 0 : idx + 1;
      end
      dev = longint'(int_sqrt(acc / n));
      if (mean < 0) dev = -dev;
      push_result(PORT_DEV, dev);

      if (pass_on && pass_cnt < PASS_ITEMS) begin
         push_result(PORT_GATE, raw);
         pass_cnt++;
      end else begin
         pass_on = 1'b0;
         pass_cnt = 0;
      end
      if (dir > TREND_LIMIT || dir < -TREND_LIMIT) push_result(PORT_GATE, raw);

      if (jump > longint'(fjump_reg) || -jump > longint'(fjump_reg)) begin
         push_result(PORT_GATE, raw);
         pass_on = 1'b1;
         pass_cnt = 0;
         for (int i = 0; i < n; i++) begin
            smp_win[i] = s;
            step_win[i] = 0;
         end
      end else if ((dev < 0 ? -dev : dev) >= longint'(mindev_reg) * 65536) begin
         pass_on = 1'b1;
         pass_cnt = 0;
         push_result(PORT_GATE, win_mean * 65536);
      end
      gated_q[$].last = 1'b1;
      prev_smp = s;
      wr_slot = (wr_slot + 1 >= n) ? 0 : wr_slot + 1;
   endfunction

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gated_q.size() == 0) begin
            report($sformatf("unexpected result port %0d value %h", rsp_port, rsp_value));
         end else begin
            x = gated_q.pop_front();
            if (rsp_port !== x.port)
               report($sformatf("port %0d, want %0d", rsp_port, x.port));
            if (rsp_value !== x.value)
               report($sformatf("value %h, want %h (port %0d)", rsp_value, x.value, x.port));
            if (rsp_last !== x.last)
               report($sformatf("last %b, want %b", rsp_last, x.last));
         end
      end
   end

   task automatic send_sample(logic [11:0] s);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      predict_sample(s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (gated_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(logic [7:0] ws, logic [11:0] md, logic [11:0] fj);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= {4'd0, ws};
      @(posedge clock);
      csr_index <= CSR_MIN_DEVIATION;
      csr_wdata <= md;
      @(posedge clock);
      csr_index <= CSR_FORCE_JUMP;
      csr_wdata <= fj;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ws_reg = ws;
      mindev_reg = md;
      fjump_reg = fj;
   endtask

   // mostly smooth drift with occasional jumps and full-range noise
   task automatic random_run(int count);
      logic [11:0] s;
      int pick, delta;
      s = prev_smp;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            delta = $urandom_range(40) - 20;
            if (pick < 30) delta = $urandom_range(12);
            s = (int'(s) + delta < 0) ? 12'd0 : (int'(s) + delta > 4095) ? 12'd4095
                : 12'(int'(s) + delta);
         end else if (pick < 85) begin
            s = s ^ 12'(($urandom_range(1, 7)) << $urandom_range(5, 9));
         end else begin
            s = 12'($urandom_range(4095));
         end
         send_sample(s);
      end
   endtask

   row_type dir_rows[] = '{
      '{12'd0,    1'b1, 3, 0},                   // all zero after reset
      '{12'd4095, 1'b1, 4, 64'd4095 <<< 16},     // full-scale jump
      '{12'd4095, 1'b1, 4, 64'd4095 <<< 16},     // pass period, flooded mean
      '{12'd0,    1'b1, 4, 0},                   // full-scale drop
      '{12'd10, 1'b0, 0, 0}, '{12'd20, 1'b0, 0, 0}, '{12'd30, 1'b0, 0, 0},
      '{12'd40, 1'b0, 0, 0}, '{12'd50, 1'b0, 0, 0}, '{12'd60, 1'b0, 0, 0},
      '{12'd70, 1'b0, 0, 0}, '{12'd60, 1'b0, 0, 0}, '{12'd50, 1'b0, 0, 0},
      '{12'd40, 1'b0, 0, 0}, '{12'd30, 1'b0, 0, 0}, '{12'd20, 1'b0, 0, 0},
      '{12'd10, 1'b0, 0, 0}, '{12'd0,  1'b0, 0, 0}, '{12'd0,  1'b0, 0, 0},
      '{12'd50, 1'b0, 0, 0}, '{12'd101, 1'b0, 0, 0}, '{12'd2730, 1'b0, 0, 0},
      '{12'd1365, 1'b0, 0, 0}
   };

   initial begin
      int before_cnt;
      for (int i = 0; i < WIN_MAX; i++) begin
         smp_win[i] = '0;
         step_win[i] = 0;
      end
      prev_smp = '0; wr_slot = 0; win_mean = 0; msq_step = 0;
      pass_on = 1'b0; pass_cnt = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         before_cnt = n_pushed;
         send_sample(dir_rows[r].sample);
         if (dir_rows[r].typed && (n_pushed - before_cnt != dir_rows[r].n_res ||
             gated_q[$].value !== dir_rows[r].last_val[VAL_W-1:0]))
            report($sformatf("row %0d does not give its listed result", r));
      end
      drain();

      write_regs(8'd128, 12'd4095, 12'd4095);
      random_run(12);
      drain();

      // window shrinks below the write slot
      write_regs(8'd3, 12'd0, 12'd1);
      snd_idle_pct = 81;
      random_run(30);
      drain();

      write_regs(8'd0, 12'd5, 12'd0);
      snd_idle_pct = 0;
      rcv_stall_pct = 81;
      hold_cycles = 4000;
      random_run(20);
      drain();

      write_regs(8'd255, 12'd1, 12'd200);
      snd_idle_pct = 23;
      rcv_stall_pct = 23;
      random_run(8);
      drain();

      for (int p = 0; p < 4; p++) begin
         write_regs(8'($urandom_range(1, 16)), 12'($urandom_range(40)),
                    12'($urandom_range(1, 300)));
         snd_idle_pct = (p == 1) ? 81 : (p == 3) ? 23 : 0;
         rcv_stall_pct = (p == 2) ? 81 : (p == 3) ? 23 : 0;
         random_run(15);
         drain();
      end

      if (errors == 0) begin
         $display("adaptive_sample_gate_tb OK");
      end else begin
         $display("adaptive_sample_gate_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #50000000;
      $display("adaptive_sample_gate_tb NOT OK");
      $finish;
   end

endmodule
